// File: design/lmin_pkg.sv
`default_nettype none
package lmin_pkg;

    localparam int MAX_CUBES = 8;
    localparam int PR_DEPTH  = 32;
    localparam int PR_IW     = 5;

    localparam logic [1:0] KIND_CUBE = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_ONE  = 2'd2;

    typedef logic [MAX_CUBES-1:0][PR_IW-1:0] t_row;

    typedef struct packed {
        logic       load;
        logic       gen_step;
        logic       ess_calc;
        logic       cov_calc;
        logic       scan_step;
        logic       suf_step;
        logic       dfs_init;
        logic       dfs_step;
        logic       ext_inc;
        logic       emit_idx;
        logic       emit_put;
        logic       emit_const;
        logic [1:0] const_kind;
    } t_cmd;

    typedef struct packed {
        logic mt_zero;
        logic on_full;
        logic gen_done;
        logic scan_done;
        logic suf_done;
        logic need_zero;
        logic ext_ok;
        logic dfs_done;
        logic sol_any;
        logic out_free;
        logic emit_last;
    } t_sts;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] care_mask;
        logic [3:0] value_bits;
        logic [2:0] solution_index;
        logic       last_in_solution;
        logic       last;
        logic       truncated;
    } t_item;

    function automatic logic [15:0] cube_cells(input logic [3:0] care, input logic [3:0] val);
        logic [15:0] m;
        m = '0;
        for (int k = 0; k < 16; k++) begin
            m[k] = ((4'(k) & care) == val);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// File: design/lmin_if.sv
`default_nettype none
interface lmin_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] minterm_mask;
    logic [15:0] dont_care_mask;
    modport source (output valid, output minterm_mask, output dont_care_mask, input ready);
    modport sink   (input valid, input minterm_mask, input dont_care_mask, output ready);
endinterface

interface lmin_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] care_mask;
    logic [3:0] value_bits;
    logic [2:0] solution_index;
    logic       last_in_solution;
    logic       last;
    logic       truncated;
    modport source (output valid, output kind, output care_mask, output value_bits,
                    output solution_index, output last_in_solution, output last,
                    output truncated, input ready);
    modport sink   (input valid, input kind, input care_mask, input value_bits,
                    input solution_index, input last_in_solution, input last,
                    input truncated, output ready);
endinterface
`default_nettype wire

// File: design/lmin_ctrl.sv
`default_nettype none
module lmin_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lmin_pkg::t_sts i_sts,
    output lmin_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRIV  = 4'd1;
    localparam logic [3:0] S_GEN   = 4'd2;
    localparam logic [3:0] S_ESS   = 4'd3;
    localparam logic [3:0] S_COV   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_SUF   = 4'd6;
    localparam logic [3:0] S_XCHK  = 4'd7;
    localparam logic [3:0] S_DFS   = 4'd8;
    localparam logic [3:0] S_XNEXT = 4'd9;
    localparam logic [3:0] S_EIDX  = 4'd10;
    localparam logic [3:0] S_EPUT  = 4'd11;
    localparam logic [3:0] S_CONST = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_kind, n_kind;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.const_kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TRIV;
                end
            end
            S_TRIV: begin
                if (i_sts.mt_zero) begin
                    n_kind  = lmin_pkg::KIND_ZERO;
                    n_state = S_CONST;
                end else if (i_sts.on_full) begin
                    n_kind  = lmin_pkg::KIND_ONE;
                    n_state = S_CONST;
                end else begin
                    n_state = S_GEN;
                end
            end
            S_GEN: begin
                o_cmd.gen_step = 1'b1;
                if (i_sts.gen_done) n_state = S_ESS;
            end
            S_ESS: begin
                o_cmd.ess_calc = 1'b1;
                n_state        = S_COV;
            end
            S_COV: begin
                o_cmd.cov_calc = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_SUF;
            end
            S_SUF: begin
                o_cmd.suf_step = 1'b1;
                if (i_sts.suf_done) n_state = i_sts.need_zero ? S_EIDX : S_XCHK;
            end
            S_XCHK: begin
                if (i_sts.ext_ok) begin
                    o_cmd.dfs_init = 1'b1;
                    n_state        = S_DFS;
                end else begin
                    n_kind  = lmin_pkg::KIND_ZERO;
                    n_state = S_CONST;
                end
            end
            S_DFS: begin
                if (i_sts.dfs_done) n_state = S_XNEXT;
                else o_cmd.dfs_step = 1'b1;
            end
            S_XNEXT: begin
                if (i_sts.sol_any) begin
                    n_state = S_EIDX;
                end else begin
                    o_cmd.ext_inc = 1'b1;
                    n_state       = S_XCHK;
                end
            end
            S_EIDX: begin
                o_cmd.emit_idx = 1'b1;
                n_state        = S_EPUT;
            end
            S_EPUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_put = 1'b1;
                    n_state        = i_sts.emit_last ? S_IDLE : S_EIDX;
                end
            end
            S_CONST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_const = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= lmin_pkg::KIND_ZERO;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule
`default_nettype wire

// File: design/lmin_dp.sv
`default_nettype none
module lmin_dp #(
    parameter int MAX_SOLUTIONS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lmin_pkg::t_cmd i_cmd,
    output lmin_pkg::t_sts      o_sts,
    input  wire logic [15:0]    i_minterm,
    input  wire logic [15:0]    i_dont_care,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output lmin_pkg::t_item     o_item
);

    localparam int SIW = (MAX_SOLUTIONS > 1) ? $clog2(MAX_SOLUTIONS) : 1;
    localparam int IW  = lmin_pkg::PR_IW;
    localparam int PD  = lmin_pkg::PR_DEPTH;

    logic [15:0]   r_mt, r_on, r_need;
    logic [7:0]    r_cube;
    logic [3:0]    r_pr_care  [PD];
    logic [3:0]    r_pr_val   [PD];
    logic [15:0]   r_pr_cells [PD];
    logic [IW:0]   r_pr_cnt;
    logic [1:0]    r_cnt [16];
    logic [IW-1:0] r_who [16];
    logic [PD-1:0] r_ess;
    logic [IW:0]   r_essn;
    logic [IW-1:0] r_ess_list [lmin_pkg::MAX_CUBES];
    logic [3:0]    r_el_n;
    logic [IW-1:0] r_ne_idx   [PD];
    logic [15:0]   r_ne_cells [PD];
    logic [15:0]   r_suffix   [PD];
    logic [IW:0]   r_ne_cnt, r_scan_i, r_suf_i;
    logic [15:0]   r_acc;
    logic [3:0]    r_extra;
    logic [2:0]    r_d;
    logic [IW:0]   r_i;
    lmin_pkg::t_row r_pick;
    logic [15:0]   r_cov [lmin_pkg::MAX_CUBES];
    logic          r_dfs_done, r_more;
    lmin_pkg::t_row r_sol [MAX_SOLUTIONS];
    logic [3:0]    r_sol_cnt;
    logic [2:0]    r_s;
    logic [4:0]    r_k;
    logic [IW-1:0] r_p;
    logic          r_o_valid;
    lmin_pkg::t_item r_item;

    logic [3:0]    g_care, g_val;
    logic [15:0]   g_cells;
    logic          g_keep, g_prime;
    logic [PD-1:0] e_ess;
    logic [15:0]   c_cov;
    logic [IW-1:0] s_i, f_j;
    logic [15:0]   f_new;
    logic [3:0]    d_rem;
    logic [15:0]   d_cur, d_new;
    logic          d_fail, d_leaf, d_hit;
    lmin_pkg::t_row d_row, m_row;
    logic [3:0]    m_essout;
    logic [4:0]    m_total, m_kk;
    logic [IW-1:0] m_p;
    logic          m_lis, m_lst, out_free;

    always_comb begin
        g_care  = r_cube[7:4];
        g_val   = r_cube[3:0];
        g_cells = lmin_pkg::cube_cells(g_care, g_val);
        g_prime = 1'b1;
        for (int b = 0; b < 4; b++) begin
            if (g_care[b] && ((lmin_pkg::cube_cells(g_care & ~(4'd1 << b),
                    g_val & ~(4'd1 << b)) & ~r_on) == 16'd0))
                g_prime = 1'b0;
        end
        g_keep = ((g_val & ~g_care) == 4'd0) && ((g_cells & ~r_on) == 16'd0) && g_prime
                 && ((g_cells & r_mt) != 16'd0) && (r_pr_cnt != (IW+1)'(PD));

        e_ess = '0;
        for (int k = 0; k < 16; k++) begin
            if (r_mt[k] && r_cnt[k] == 2'd1) e_ess[r_who[k]] = 1'b1;
        end
        c_cov = '0;
        for (int i = 0; i < PD; i++) begin
            if (r_ess[i]) c_cov = c_cov | r_pr_cells[i];
        end

        s_i   = r_scan_i[IW-1:0];
        f_j   = IW'(r_suf_i - (IW+1)'(1));
        f_new = r_acc | r_ne_cells[f_j];

        d_rem  = r_extra - {1'b0, r_d};
        d_cur  = r_cov[r_d];
        d_new  = d_cur | r_ne_cells[r_i[IW-1:0]];
        d_fail = (({1'b0, r_i} + (IW+2)'(d_rem)) > {1'b0, r_ne_cnt})
                 || (((d_cur | r_suffix[r_i[IW-1:0]]) & r_need) != r_need);
        d_leaf = ({1'b0, r_d} == (r_extra - 4'd1));
        d_hit  = ((d_new & r_need) == r_need);
        d_row  = r_pick;
        d_row[r_d] = r_i[IW-1:0];

        m_essout = (r_essn > (IW+1)'(lmin_pkg::MAX_CUBES)) ? 4'(lmin_pkg::MAX_CUBES)
                                                           : r_essn[3:0];
        m_total  = 5'(m_essout) + 5'(r_extra);
        m_kk     = r_k - 5'(m_essout);
        m_row    = r_sol[r_s[SIW-1:0]];
        m_p      = (r_k < 5'(m_essout)) ? r_ess_list[r_k[2:0]] : r_ne_idx[m_row[m_kk[2:0]]];
        m_lis    = (r_k == m_total - 5'd1);
        m_lst    = m_lis && ({1'b0, r_s} == r_sol_cnt - 4'd1);
        out_free = !r_o_valid || i_out_ready;
    end

    always_comb begin
        o_sts.mt_zero   = (r_mt == 16'd0);
        o_sts.on_full   = (r_on == 16'hFFFF);
        o_sts.gen_done  = (r_cube == 8'hFF);
        o_sts.scan_done = (r_scan_i == r_pr_cnt);
        o_sts.suf_done  = (r_suf_i == '0);
        o_sts.need_zero = (r_need == 16'd0);
        o_sts.ext_ok    = (({3'b0, r_extra} + {1'b0, r_essn}) <= 7'(lmin_pkg::MAX_CUBES))
                          && ({2'b0, r_extra} <= r_ne_cnt);
        o_sts.dfs_done  = r_dfs_done;
        o_sts.sol_any   = (r_sol_cnt != 4'd0);
        o_sts.out_free  = out_free;
        o_sts.emit_last = m_lst;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mt     <= i_minterm;
            r_on     <= i_minterm | i_dont_care;
            r_cube   <= '0;
            r_pr_cnt <= '0;
            for (int k = 0; k < 16; k++) r_cnt[k] <= 2'd0;
        end
        if (i_cmd.gen_step) begin
            r_cube <= r_cube + 8'd1;
            if (g_keep) begin
                r_pr_care[r_pr_cnt[IW-1:0]]  <= g_care;
                r_pr_val[r_pr_cnt[IW-1:0]]   <= g_val;
                r_pr_cells[r_pr_cnt[IW-1:0]] <= g_cells;
                r_pr_cnt <= r_pr_cnt + (IW+1)'(1);
                for (int k = 0; k < 16; k++) begin
                    if (g_cells[k]) begin
                        if (r_cnt[k] == 2'd0) begin
                            r_cnt[k] <= 2'd1;
                            r_who[k] <= r_pr_cnt[IW-1:0];
                        end else if (r_cnt[k] == 2'd1) begin
                            r_cnt[k] <= 2'd2;
                        end
                    end
                end
            end
        end
        if (i_cmd.ess_calc) r_ess <= e_ess;
        if (i_cmd.cov_calc) begin
            r_need   <= r_mt & ~c_cov;
            r_essn   <= (IW+1)'($countones(r_ess));
            r_el_n   <= '0;
            r_ne_cnt <= '0;
            r_scan_i <= '0;
        end
        if (i_cmd.scan_step) begin
            if (r_scan_i == r_pr_cnt) begin
                r_suf_i <= r_ne_cnt;
                r_acc   <= '0;
            end else begin
                r_scan_i <= r_scan_i + (IW+1)'(1);
                if (r_ess[s_i]) begin
                    if (r_el_n < 4'(lmin_pkg::MAX_CUBES)) begin
                        r_ess_list[r_el_n[2:0]] <= s_i;
                        r_el_n <= r_el_n + 4'd1;
                    end
                end else if ((r_pr_cells[s_i] & r_need) != 16'd0) begin
                    r_ne_idx[r_ne_cnt[IW-1:0]]   <= s_i;
                    r_ne_cells[r_ne_cnt[IW-1:0]] <= r_pr_cells[s_i];
                    r_ne_cnt <= r_ne_cnt + (IW+1)'(1);
                end
            end
        end
        if (i_cmd.suf_step) begin
            if (r_suf_i != '0) begin
                r_suffix[f_j] <= f_new;
                r_acc         <= f_new;
                r_suf_i       <= r_suf_i - (IW+1)'(1);
            end else begin
                r_extra   <= (r_need == 16'd0) ? 4'd0 : 4'd1;
                r_sol_cnt <= (r_need == 16'd0) ? 4'd1 : 4'd0;
                r_more    <= 1'b0;
                r_s       <= '0;
                r_k       <= '0;
            end
        end
        if (i_cmd.ext_inc) r_extra <= r_extra + 4'd1;
        if (i_cmd.dfs_init) begin
            r_d        <= '0;
            r_i        <= '0;
            r_cov[0]   <= '0;
            r_dfs_done <= 1'b0;
        end
        if (i_cmd.dfs_step) begin
            if (d_fail) begin
                if (r_d == 3'd0) begin
                    r_dfs_done <= 1'b1;
                end else begin
                    r_d <= r_d - 3'd1;
                    r_i <= {1'b0, r_pick[r_d - 3'd1]} + (IW+1)'(1);
                end
            end else begin
                r_pick[r_d] <= r_i[IW-1:0];
                r_i         <= r_i + (IW+1)'(1);
                if (d_leaf) begin
                    if (d_hit) begin
                        if (r_sol_cnt < 4'(MAX_SOLUTIONS)) begin
                            r_sol[r_sol_cnt[SIW-1:0]] <= d_row;
                            r_sol_cnt <= r_sol_cnt + 4'd1;
                        end else begin
                            r_more     <= 1'b1;
                            r_dfs_done <= 1'b1;
                        end
                    end
                end else begin
                    r_cov[r_d + 3'd1] <= d_new;
                    r_d <= r_d + 3'd1;
                end
            end
        end
        if (i_cmd.emit_idx) r_p <= m_p;
        if (i_cmd.emit_put) begin
            r_item.kind             <= lmin_pkg::KIND_CUBE;
            r_item.care_mask        <= r_pr_care[r_p];
            r_item.value_bits       <= r_pr_val[r_p];
            r_item.solution_index   <= r_s;
            r_item.last_in_solution <= m_lis;
            r_item.last             <= m_lst;
            r_item.truncated        <= r_more;
            if (m_lis) begin
                r_k <= '0;
                r_s <= r_s + 3'd1;
            end else begin
                r_k <= r_k + 5'd1;
            end
        end
        if (i_cmd.emit_const) begin
            r_item.kind             <= i_cmd.const_kind;
            r_item.care_mask        <= '0;
            r_item.value_bits       <= '0;
            r_item.solution_index   <= '0;
            r_item.last_in_solution <= 1'b1;
            r_item.last             <= 1'b1;
            r_item.truncated        <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_put || i_cmd.emit_const) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_item      = r_item;

endmodule
`default_nettype wire

// File: design/four_variable_logic_minimizer.sv
// After a trivial check the block scans all 256 cubes for primes, finds the essential ones,
// scans the primes, builds suffix covers, and runs a check and a pruned search per cover size
// tried, then emits the results; constant functions skip from the trivial check to output.
// One function at a time; every non-constant function goes through the whole 256-cube scan.
// The cover search visits one node of the pruned subset tree per cycle.
// Reset (synchronous, active low) clears the controller and the output valid only.
`default_nettype none
module four_variable_logic_minimizer #(
    parameter int MAX_SOLUTIONS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lmin_in_if.sink     i_in,
    lmin_out_if.source  o_out
);

    lmin_pkg::t_cmd  cmd;
    lmin_pkg::t_sts  sts;
    lmin_pkg::t_item item;
    logic            in_ready, out_valid;

    lmin_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lmin_dp #(.MAX_SOLUTIONS(MAX_SOLUTIONS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_minterm   (i_in.minterm_mask),
        .i_dont_care (i_in.dont_care_mask),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_item      (item)
    );

    assign i_in.ready             = in_ready;
    assign o_out.valid            = out_valid;
    assign o_out.kind             = item.kind;
    assign o_out.care_mask        = item.care_mask;
    assign o_out.value_bits       = item.value_bits;
    assign o_out.solution_index   = item.solution_index;
    assign o_out.last_in_solution = item.last_in_solution;
    assign o_out.last             = item.last;
    assign o_out.truncated        = item.truncated;

endmodule
`default_nettype wire

// File: dv/tb_four_variable_logic_minimizer.sv
`default_nettype none
module tb_four_variable_logic_minimizer;

    localparam int N_SOL = 8;

    typedef struct packed {
        logic [15:0]     mt;
        logic [15:0]     dc;
        logic            has_exp;
        lmin_pkg::t_item exp;
    } t_row_stim;

    logic i_clk;
    logic i_rst_n;

    lmin_in_if  in_ch();
    lmin_out_if out_ch();

    four_variable_logic_minimizer #(.MAX_SOLUTIONS(N_SOL)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    lmin_pkg::t_item cover_q[$];
    int    n_err;
    int    n_items;
    int    n_results;
    int    n_trunc;
    int    n_const;
    int    src_idle_pct;
    int    snk_idle_pct;
    bit    snk_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [15:0] cells_of(input logic [3:0] care, input logic [3:0] val);
        logic [15:0] m;
        m = '0;
        for (int k = 0; k < 16; k++) begin
            m[k] = ((k[3:0] & care) == val);
        end
        return m;
    endfunction

    function automatic lmin_pkg::t_item mk_item(input logic [1:0] kind,
                                                input logic [3:0] care,
                                                input logic [3:0] val, input logic [2:0] sidx,
                                                input logic lis, input logic lst,
                                                input logic tr);
        lmin_pkg::t_item it;
        it.kind = kind;
        it.care_mask = care;
        it.value_bits = val;
        it.solution_index = sidx;
        it.last_in_solution = lis;
        it.last = lst;
        it.truncated = tr;
        return it;
    endfunction

    // exact minimum covers of one function, appended to cover_q
    task automatic predict_covers(input logic [15:0] mt, input logic [15:0] dc);
        logic [15:0] on_set;
        logic [3:0]  p_care [81];
        logic [3:0]  p_val [81];
        logic [15:0] p_cells [81];
        bit          is_ess [81];
        int          np;
        int          ess_ids[$];
        int          opt_ids[$];
        logic [15:0] ess_cov;
        logic [15:0] need;
        int          sols[N_SOL][lmin_pkg::MAX_CUBES];
        int          nsol;
        bit          more;
        int          extra;
        int          pk[lmin_pkg::MAX_CUBES];
        int          lvl;
        logic [15:0] cv;
        logic [15:0] c;
        bit          prime;
        int          cnt;
        int          who;
        int          total;
        int          n_ess;
        int          p;
        bit          done;
        on_set = mt | dc;
        np = 0;
        nsol = 0;
        more = 1'b0;
        extra = 0;
        ess_cov = '0;
        if (mt == 16'd0) begin
            cover_q = {cover_q, mk_item(lmin_pkg::KIND_ZERO, 4'd0, 4'd0, 3'd0,
                                        1'b1, 1'b1, 1'b0)};
            return;
        end
        if (on_set == 16'hFFFF) begin
            cover_q = {cover_q, mk_item(lmin_pkg::KIND_ONE, 4'd0, 4'd0, 3'd0,
                                        1'b1, 1'b1, 1'b0)};
            return;
        end
        for (int cr = 0; cr < 16; cr++) begin
            for (int vl = 0; vl < 16; vl++) begin
                if ((vl & ~cr) != 0) continue;
                c = cells_of(cr[3:0], vl[3:0]);
                if ((c & on_set) != c) continue;
                prime = 1'b1;
                for (int b = 0; b < 4; b++) begin
                    if (cr[b]) begin
                        logic [15:0] g;
                        g = cells_of(cr[3:0] & ~(4'd1 << b), vl[3:0] & ~(4'd1 << b));
                        if ((g & on_set) == g) prime = 1'b0;
                    end
                end
                if (!prime || (c & mt) == 16'd0) continue;
                p_care[np] = cr[3:0];
                p_val[np] = vl[3:0];
                p_cells[np] = c;
                is_ess[np] = 1'b0;
                np++;
            end
        end
        for (int k = 0; k < 16; k++) begin
            if (!mt[k]) continue;
            cnt = 0;
            who = 0;
            for (int i = 0; i < np; i++) begin
                if (p_cells[i][k]) begin
                    cnt++;
                    who = i;
                end
            end
            if (cnt == 1) is_ess[who] = 1'b1;
        end
        for (int i = 0; i < np; i++) begin
            if (is_ess[i]) begin
                ess_ids = {ess_ids, i};
                ess_cov |= p_cells[i];
            end
        end
        need = mt & ~ess_cov;
        for (int i = 0; i < np; i++) begin
            if (!is_ess[i] && (p_cells[i] & need) != 16'd0) opt_ids = {opt_ids, i};
        end
        if (need == 16'd0) begin
            nsol = 1;
        end else begin
            // lexicographic combination walk; order matches the pruned search
            for (extra = 1;
                 extra + ess_ids.size() <= lmin_pkg::MAX_CUBES && extra <= opt_ids.size();
                 extra++) begin
                for (int i = 0; i < extra; i++) pk[i] = i;
                done = 1'b0;
                while (!done) begin
                    cv = '0;
                    for (int i = 0; i < extra; i++) cv |= p_cells[opt_ids[pk[i]]];
                    if ((cv & need) == need) begin
                        if (nsol < N_SOL) begin
                            for (int i = 0; i < extra; i++) sols[nsol][i] = pk[i];
                            nsol++;
                        end else begin
                            more = 1'b1;
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        lvl = extra - 1;
                        while (lvl >= 0 && pk[lvl] == opt_ids.size() - extra + lvl) lvl--;
                        if (lvl < 0) begin
                            done = 1'b1;
                        end else begin
                            pk[lvl]++;
                            for (int i = lvl + 1; i < extra; i++) pk[i] = pk[i-1] + 1;
                        end
                    end
                end
                if (nsol > 0) break;
            end
            if (nsol == 0) begin
                cover_q = {cover_q, mk_item(lmin_pkg::KIND_ZERO, 4'd0, 4'd0, 3'd0,
                                            1'b1, 1'b1, 1'b0)};
                return;
            end
        end
        if (more) n_trunc++;
        n_ess = (ess_ids.size() > lmin_pkg::MAX_CUBES) ? lmin_pkg::MAX_CUBES : ess_ids.size();
        total = n_ess + (need == 16'd0 ? 0 : extra);
        for (int s = 0; s < nsol; s++) begin
            for (int k = 0; k < total; k++) begin
                p = (k < n_ess) ? ess_ids[k] : opt_ids[sols[s][k - n_ess]];
                cover_q = {cover_q, mk_item(lmin_pkg::KIND_CUBE, p_care[p], p_val[p], s[2:0],
                                            k == total - 1,
                                            (k == total - 1) && (s == nsol - 1), more)};
            end
        end
    endtask

    task automatic send_fn(input logic [15:0] mt, input logic [15:0] dc,
                           input bit has_exp, input lmin_pkg::t_item exp);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.minterm_mask <= mt;
        in_ch.dont_care_mask <= dc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (has_exp) cover_q = {cover_q, exp};
        else predict_covers(mt, dc);
        if (mt == 16'd0 || (mt | dc) == 16'hFFFF) n_const++;
        n_items++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (cover_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
            if (out_ch.valid && out_ch.ready) begin
                lmin_pkg::t_item got;
                lmin_pkg::t_item want;
                got = mk_item(out_ch.kind, out_ch.care_mask, out_ch.value_bits,
                              out_ch.solution_index, out_ch.last_in_solution,
                              out_ch.last, out_ch.truncated);
                n_results++;
                if (cover_q.size() == 0) begin
                    $display("%0t unexpected transaction %p", $time, got);
                    n_err++;
                end else begin
                    want = cover_q.pop_front();
                    if (got.kind != want.kind || got.care_mask != want.care_mask ||
                        got.value_bits != want.value_bits ||
                        got.solution_index != want.solution_index ||
                        got.last_in_solution != want.last_in_solution ||
                        got.last != want.last || got.truncated != want.truncated) begin
                        $display("%0t mismatch expected %p actual %p", $time, want, got);
                        n_err++;
                    end
                end
            end
        end
    end

    t_row_stim directed[] = '{
        '{16'h0000, 16'h0000, 1'b1, '{lmin_pkg::KIND_ZERO, 4'd0, 4'd0, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{16'h0000, 16'hFFFF, 1'b1, '{lmin_pkg::KIND_ZERO, 4'd0, 4'd0, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{16'hFFFF, 16'h0000, 1'b1, '{lmin_pkg::KIND_ONE,  4'd0, 4'd0, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{16'h0001, 16'hFFFE, 1'b1, '{lmin_pkg::KIND_ONE,  4'd0, 4'd0, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{16'hFFFF, 16'hFFFF, 1'b1, '{lmin_pkg::KIND_ONE,  4'd0, 4'd0, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{16'h0001, 16'h0000, 1'b1, '{lmin_pkg::KIND_CUBE, 4'hF, 4'h0, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{16'h8000, 16'h0000, 1'b1, '{lmin_pkg::KIND_CUBE, 4'hF, 4'hF, 3'd0, 1'b1, 1'b1, 1'b0}},
        '{16'h7FFF, 16'h0000, 1'b0, '0},
        '{16'hFFFE, 16'h0000, 1'b0, '0},
        '{16'h6996, 16'h0000, 1'b0, '0},
        '{16'h9669, 16'h0000, 1'b0, '0},
        '{16'h0001, 16'h0002, 1'b0, '0},
        '{16'h0F0F, 16'hF0F0, 1'b0, '0},
        '{16'h0003, 16'h0003, 1'b0, '0},
        '{16'h0000, 16'h1234, 1'b0, '0},
        '{16'h0001, 16'h8000, 1'b0, '0},
        '{16'hA5A5, 16'h5A00, 1'b0, '0},
        '{16'h7E7E, 16'h8181, 1'b0, '0},
        '{16'h5A5A, 16'h0000, 1'b0, '0},
        '{16'h0660, 16'h9009, 1'b0, '0},
        '{16'h1248, 16'h0000, 1'b0, '0},
        '{16'h0E1C, 16'h2000, 1'b0, '0},
        '{16'hFF00, 16'h00FF, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 1'b0, '0}
    };

    task automatic random_fn();
        logic [15:0] mt;
        logic [15:0] dc;
        mt = 16'($urandom());
        dc = 16'($urandom());
        case ($urandom_range(5))
            0: dc = '0;
            1: mt = mt & 16'($urandom());
            2: dc = dc & 16'($urandom());
            3: begin
                mt = mt & 16'($urandom()) & 16'($urandom());
                dc = dc & 16'($urandom());
            end
            default: ;
        endcase
        send_fn(mt, dc, 1'b0, '0);
    endtask

    initial begin
        n_err = 0;
        n_items = 0;
        n_results = 0;
        n_trunc = 0;
        n_const = 0;
        snk_hold = 1'b0;
        src_idle_pct = 38;
        snk_idle_pct = 62;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.minterm_mask = '0;
        in_ch.dont_care_mask = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_fn(directed[i].mt, directed[i].dc, directed[i].has_exp, directed[i].exp);
        end
        drain();

        repeat (80) random_fn();
        drain();

        src_idle_pct = 62;
        snk_idle_pct = 38;
        fork
            begin
                snk_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                snk_hold = 1'b0;
            end
            repeat (6) random_fn();
        join
        repeat (74) random_fn();
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (90) random_fn();
        drain();

        $display("%0d functions sent, %0d result transactions, %0d constant, %0d truncated",
                 n_items, n_results, n_const, n_trunc);
        if (n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
design/lmin_pkg.sv
design/lmin_if.sv
design/lmin_ctrl.sv
design/lmin_dp.sv
design/four_variable_logic_minimizer.sv
dv/tb_four_variable_logic_minimizer.sv
